### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("spq check failed");

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("spq check failed");

`endif

### hw/rtl/spq_pkg.sv
// Shared constants, codes, types and helpers of the signal pending queue unit.
// No dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_SIGNALS = 64;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int SIG_W       = 7;
    localparam int INFO_W      = 32;
    localparam int MASK_W      = 64;
    localparam int CI_DEPTH    = 64;
    localparam int CI_AW       = $clog2(CI_DEPTH);

    // request types
    localparam logic [2:0] REQ_RAISE = 3'd0;
    localparam logic [2:0] REQ_TAKE  = 3'd1;
    localparam logic [2:0] REQ_MASK  = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    // decoded operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_BAD   = 3'd1;
    localparam logic [2:0] OP_RAISE = 3'd2;
    localparam logic [2:0] OP_TAKE  = 3'd3;
    localparam logic [2:0] OP_MASK  = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;
    localparam logic [2:0] OP_CLEAR = 3'd6;

    // mask modes
    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SET     = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOBUF = 2'd2;

    localparam logic [SIG_W-1:0] FRT_RESET = 7'd32;

    // kill (9) and stop (19) can never be blocked
    localparam logic [MASK_W-1:0] KILL_STOP_MASK = (64'd1 << 8) | (64'd1 << 18);

    typedef struct packed {
        logic [2:0]        op;
        logic [SIG_W-1:0]  signo;
        logic              ignored;
        logic [INFO_W-1:0] info;
        logic [1:0]        how;
        logic [MASK_W-1:0] operand;
        logic              use_alt;
        logic              given;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIG_W-1:0]  dsig;
        logic [INFO_W-1:0] dinfo;
        logic [MASK_W-1:0] old_mask;
        logic [MASK_W-1:0] pset;
    } t_res;

    function automatic logic [MASK_W-1:0] sig_bit(input logic [SIG_W-1:0] s);
        logic [MASK_W-1:0] b;
        b = '0;
        if (s != '0 && s <= SIG_W'(NUM_SIGNALS)) begin
            b = MASK_W'(1) << 6'(s - 7'd1);
        end
        return b;
    endfunction

    function automatic logic [QIDX_W-1:0] q_next(input logic [QIDX_W-1:0] i);
        return (i == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

### hw/rtl/spq_if.sv
// Channel interfaces: request, response and configuration write.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [SIG_W-1:0]  signal_number;
    logic              handler_ignored;
    logic [INFO_W-1:0] info_word;
    logic [1:0]        mask_how;
    logic [MASK_W-1:0] mask_operand;
    logic              use_alt_mask;
    logic              mask_given;

    modport source (output valid, req_type, signal_number, handler_ignored, info_word,
                    mask_how, mask_operand, use_alt_mask, mask_given, input ready);
    modport sink   (input valid, req_type, signal_number, handler_ignored, info_word,
                    mask_how, mask_operand, use_alt_mask, mask_given, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [SIG_W-1:0]  delivered_signal;
    logic [INFO_W-1:0] delivered_info;
    logic [MASK_W-1:0] old_mask;
    logic [MASK_W-1:0] pending_set;

    modport source (output valid, status, delivered_signal, delivered_info, old_mask,
                    pending_set, input ready);
    modport sink   (input valid, status, delivered_signal, delivered_info, old_mask,
                    pending_set, output ready);
endinterface

interface spq_cfg_if import spq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SIG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/spq_front.sv
// Front end: accepts request transactions, decodes them, queues two commands.
// Depends on spq_pkg and spq_req_if.
module spq_front import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd       r_fifo [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;

    always_comb begin
        dec.signo   = i_req.signal_number;
        dec.ignored = i_req.handler_ignored;
        dec.info    = i_req.info_word;
        dec.how     = i_req.mask_how;
        dec.operand = i_req.mask_operand;
        dec.use_alt = i_req.use_alt_mask;
        dec.given   = i_req.mask_given;
        unique case (i_req.req_type)
            REQ_RAISE: begin
                if (i_req.signal_number == '0) begin
                    dec.op = OP_NOP;
                end else if (i_req.signal_number > SIG_W'(NUM_SIGNALS)) begin
                    dec.op = OP_BAD;
                end else begin
                    dec.op = OP_RAISE;
                end
            end
            REQ_TAKE:  dec.op = OP_TAKE;
            REQ_MASK:  dec.op = OP_MASK;
            REQ_READ:  dec.op = OP_READ;
            REQ_CLEAR: dec.op = OP_CLEAR;
            default:   dec.op = OP_BAD;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

### hw/rtl/spq_back.sv
// Back end: signal state, real-time ring and classic info memories, sequencer, result register.
// Depends on spq_pkg, spq_rsp_if and spq_cfg_if.
module spq_back import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    spq_cfg_if.sink   i_cfg,
    spq_rsp_if.source o_rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_SH_RD    = 4'd3;
    localparam logic [3:0] S_SH_WR    = 4'd4;
    localparam logic [3:0] S_CL_BYTE  = 4'd5;
    localparam logic [3:0] S_CL_BIT   = 4'd6;
    localparam logic [3:0] S_CL_INFO  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    localparam int ENT_W = SIG_W + INFO_W;

    logic [3:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    t_res              r_res, n_res;
    logic [MASK_W-1:0] r_m, n_m;
    logic [QIDX_W-1:0] r_idx, n_idx, r_j, n_j;
    logic [2:0]        r_byte, n_byte;
    logic [SIG_W-1:0]  r_frt;
    logic [MASK_W-1:0] r_mask, n_mask, r_pend, n_pend;
    logic [QIDX_W-1:0] r_head, n_head, r_tail, n_tail;
    logic              r_recheck, n_recheck;
    logic              r_out_valid;
    t_res              r_out;

    logic [ENT_W-1:0]  rt_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0]  r_rt_rdata;
    logic [INFO_W-1:0] ci_mem [CI_DEPTH];
    logic [INFO_W-1:0] r_ci_rdata;

    logic              rt_we, ci_we;
    logic [QIDX_W-1:0] rt_wa, rt_ra;
    logic [ENT_W-1:0]  rt_wd;
    logic [CI_AW-1:0]  ci_wa, ci_ra;

    logic [MASK_W-1:0] ready_bits, new_mask, ent_bit;
    logic [7:0]        sel_byte;
    logic [2:0]        first_byte, first_bit;
    logic              load_out;

    assign ready_bits = r_pend & ~r_m;
    assign ent_bit    = sig_bit(r_rt_rdata[ENT_W-1:INFO_W]);
    assign sel_byte   = ready_bits[r_byte*8 +: 8];
    assign rt_ra      = (r_state == S_SH_RD) ? r_j : r_idx;
    assign ci_ra      = {r_byte, first_bit};

    always_comb begin
        first_byte = '0;
        for (int k = 7; k >= 0; k--) begin
            if (ready_bits[k*8 +: 8] != '0) begin
                first_byte = 3'(k);
            end
        end
        first_bit = '0;
        for (int k = 7; k >= 0; k--) begin
            if (sel_byte[k]) begin
                first_bit = 3'(k);
            end
        end
    end

    always_comb begin
        case (i_cmd.how)
            HOW_BLOCK:   new_mask = r_mask | i_cmd.operand;
            HOW_UNBLOCK: new_mask = r_mask & ~i_cmd.operand;
            HOW_SET:     new_mask = i_cmd.operand;
            default:     new_mask = r_mask;
        endcase
        new_mask = new_mask & ~KILL_STOP_MASK;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_m       = r_m;
        n_idx     = r_idx;
        n_j       = r_j;
        n_byte    = r_byte;
        n_mask    = r_mask;
        n_pend    = r_pend;
        n_head    = r_head;
        n_tail    = r_tail;
        n_recheck = r_recheck;
        o_cmd_pop = 1'b0;
        rt_we     = 1'b0;
        rt_wa     = r_tail;
        rt_wd     = {i_cmd.signo, i_cmd.info};
        ci_we     = 1'b0;
        ci_wa     = CI_AW'(i_cmd.signo - 7'd1);
        load_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop      = 1'b1;
                    n_cmd          = i_cmd;
                    n_res          = '0;
                    n_res.old_mask = r_mask;
                    n_m            = i_cmd.use_alt ? i_cmd.operand : r_mask;
                    n_idx          = r_head;
                    n_state        = S_DONE;
                    unique case (i_cmd.op)
                        OP_NOP: ;
                        OP_BAD: n_res.status = ST_INVAL;
                        OP_RAISE: begin
                            n_recheck = 1'b1;
                            if (!i_cmd.ignored) begin
                                if (i_cmd.signo < r_frt) begin
                                    n_pend = r_pend | sig_bit(i_cmd.signo);
                                    ci_we  = 1'b1;
                                end else if (q_next(r_tail) == r_head) begin
                                    n_res.status = ST_NOBUF;
                                end else begin
                                    rt_we  = 1'b1;
                                    n_tail = q_next(r_tail);
                                end
                            end
                        end
                        OP_TAKE: begin
                            if (r_recheck || i_cmd.use_alt) begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_MASK: begin
                            if (i_cmd.given) begin
                                n_mask = new_mask;
                                if (i_cmd.how != HOW_BLOCK && i_cmd.how != HOW_UNBLOCK &&
                                    i_cmd.how != HOW_SET) begin
                                    n_res.status = ST_INVAL;
                                end
                                if ((r_mask & ~new_mask) != '0) begin
                                    n_recheck = 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            n_res.pset = r_pend;
                            n_state    = S_SCAN_RD;
                        end
                        OP_CLEAR: begin
                            n_pend = '0;
                            n_head = '0;
                            n_tail = '0;
                        end
                        default: n_res.status = ST_INVAL;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_tail) begin
                    n_state = (r_cmd.op == OP_TAKE) ? S_CL_BYTE : S_DONE;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_state = S_SCAN_RD;
                n_idx   = q_next(r_idx);
                if (r_cmd.op == OP_READ) begin
                    n_res.pset = r_res.pset | ent_bit;
                end else if ((r_m & ent_bit) == '0) begin
                    n_res.dsig  = r_rt_rdata[ENT_W-1:INFO_W];
                    n_res.dinfo = r_rt_rdata[INFO_W-1:0];
                    if (r_idx == r_head) begin
                        n_head  = q_next(r_head);
                        n_state = S_DONE;
                    end else begin
                        // close the gap: pull later entries down one slot
                        n_idx   = r_idx;
                        n_j     = q_next(r_idx);
                        n_state = S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                if (r_j == r_tail) begin
                    n_tail  = r_idx;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                rt_we   = 1'b1;
                rt_wa   = r_idx;
                rt_wd   = r_rt_rdata;
                n_idx   = r_j;
                n_j     = q_next(r_j);
                n_state = S_SH_RD;
            end
            S_CL_BYTE: begin
                if (ready_bits == '0) begin
                    n_recheck = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    n_byte  = first_byte;
                    n_state = S_CL_BIT;
                end
            end
            S_CL_BIT: begin
                n_pend     = r_pend & ~(MASK_W'(1) << {r_byte, first_bit});
                n_res.dsig = SIG_W'({r_byte, first_bit}) + 7'd1;
                n_state    = S_CL_INFO;
            end
            S_CL_INFO: begin
                n_res.dinfo = r_ci_rdata;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rt_we) begin
            rt_mem[rt_wa] <= rt_wd;
        end
        r_rt_rdata <= rt_mem[rt_ra];
        if (ci_we) begin
            ci_mem[ci_wa] <= i_cmd.info;
        end
        r_ci_rdata <= ci_mem[ci_ra];
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_m    <= n_m;
        r_idx  <= n_idx;
        r_j    <= n_j;
        r_byte <= n_byte;
        if (load_out) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frt       <= FRT_RESET;
            r_mask      <= '0;
            r_pend      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_recheck   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mask    <= n_mask;
            r_pend    <= n_pend;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_recheck <= n_recheck;
            if (i_cfg.valid) begin
                r_frt <= i_cfg.data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cfg.ready            = 1'b1;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out.status;
    assign o_rsp.delivered_signal = r_out.dsig;
    assign o_rsp.delivered_info   = r_out.dinfo;
    assign o_rsp.old_mask         = r_out.old_mask;
    assign o_rsp.pending_set      = r_out.pset;

endmodule

### hw/rtl/signal_pending_queue_unit.sv
// Signal pending queue unit: block mask, classic pending bits, real-time ring.
// Raise, mask, clear, no-op and bad requests, and a take with nothing to recheck, go to the response.
// Read pending walks the whole ring. Take walks the ring to the first unblocked entry and moves
// each later entry down a slot if it was not the head; with none in the ring it tries classic bits.
// The back end works on one request at a time; the front queue holds two more; stalls add directly.
// Reset (sync, active low) clears mask, pending bits, ring pointers, response; config 32.
module signal_pending_queue_unit import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_cfg_if.sink   i_cfg,
    spq_rsp_if.source o_rsp
);

    // decoded commands from the front queue to the sequencer
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // front: takes the request transaction, decodes raise validity and type
    spq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: owns all signal state, walks the ring, registers the response
    spq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (i_cfg),
        .o_rsp       (o_rsp)
    );

endmodule

### hw/rtl/spq_checker.sv
// Port-level checks of the signal pending queue unit, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [1:0]        rsp_status,
    input logic [SIG_W-1:0]  rsp_signal,
    input logic [MASK_W-1:0] rsp_pset
);

    `SPQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !rsp_valid)
    `SPQ_ASSERT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pset))
    `SPQ_ASSERT(a_sig_range, i_clk, i_rst_n, rsp_valid |-> rsp_signal <= SIG_W'(NUM_SIGNALS))
    `SPQ_ASSERT(a_deliver_ok, i_clk, i_rst_n, rsp_valid && rsp_signal != '0 |-> rsp_status == ST_OK)

endmodule

bind signal_pending_queue_unit spq_checker u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .rsp_valid  (o_rsp.valid),
    .rsp_ready  (o_rsp.ready),
    .rsp_status (o_rsp.status),
    .rsp_signal (o_rsp.delivered_signal),
    .rsp_pset   (o_rsp.pending_set)
);

### tb/sv/spq_tb_pkg.sv
// Request item type and stimulus helpers for the signal pending queue testbench.
// Depends on spq_pkg.
`timescale 1ns / 1ps
package spq_tb_pkg;
    import spq_pkg::*;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [SIG_W-1:0]  signo;
        logic              ignored;
        logic [INFO_W-1:0] info;
        logic [1:0]        how;
        logic [MASK_W-1:0] operand;
        logic              use_alt;
        logic              given;
    } sig_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIG_W-1:0]  dsig;
        logic [INFO_W-1:0] dinfo;
        logic [MASK_W-1:0] old_mask;
        logic [MASK_W-1:0] pset;
    } sig_rsp_t;

    function automatic logic [MASK_W-1:0] rand_mask();
        logic [MASK_W-1:0] m;
        m = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: m = '0;
            1: m = ~'0;
            2: m = m & {$urandom(), $urandom()};
            default: ;
        endcase
        return m;
    endfunction
endpackage

### tb/sv/testbench.sv
// Top-level testbench of signal_pending_queue_unit: drives requests and config writes,
// predicts each response and compares it field by field.
// Depends on spq_pkg, spq_tb_pkg, spq_if and the block's RTL.
`timescale 1ns / 1ps
module testbench;
    import spq_pkg::*;
    import spq_tb_pkg::*;

    localparam int IDLE_PCT    = 23;
    localparam int WDOG_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1950;
    localparam logic [1:0] HOW_BAD_MODE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();
    spq_cfg_if cfg_if ();

    signal_pending_queue_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow copy of the thread's signal state.
    // ------------------------------------------------------------------
    logic [SIG_W-1:0]  rt_first;
    logic [MASK_W-1:0] blk_mask;
    logic [MASK_W-1:0] pend_bits;
    logic [INFO_W-1:0] classic_word [CI_DEPTH];
    logic [SIG_W+INFO_W-1:0] rt_ring [QUEUE_DEPTH];
    int unsigned       rt_head, rt_tail;
    bit                recheck;

    sig_rsp_t expected_rsps [$];
    int  err_cnt   = 0;
    bit  no_stall  = 1'b0;   // quiet stretch: neither side idles

    function automatic logic [MASK_W-1:0] bit_of(input int unsigned s);
        if (s < 1 || s > NUM_SIGNALS) return '0;
        return MASK_W'(1) << (s - 1);
    endfunction

    function automatic int unsigned ring_step(input int unsigned i);
        return (i + 1) % QUEUE_DEPTH;
    endfunction

    function automatic int unsigned ring_sig(input int unsigned i);
        return rt_ring[QIDX_W'(i)][SIG_W+INFO_W-1:INFO_W];
    endfunction

    function automatic void reset_shadow();
        rt_first  = FRT_RESET;
        blk_mask  = '0;
        pend_bits = '0;
        rt_head   = 0;
        rt_tail   = 0;
        recheck   = 1'b0;
    endfunction

    // Advances the shadow state by one request and returns the response it causes.
    function automatic sig_rsp_t predict_signal_state(input sig_req_t r);
        sig_rsp_t          o;
        logic [MASK_W-1:0] m, rdy;
        int unsigned       i, j;
        bit                found;
        o = '{status: ST_OK, dsig: '0, dinfo: '0, old_mask: blk_mask, pset: '0};
        case (r.req_type)
            REQ_RAISE: begin
                if (r.signo == 0) begin
                end else if (r.signo > NUM_SIGNALS) begin
                    o.status = ST_INVAL;
                end else begin
                    if (r.ignored) begin
                    end else if (r.signo < rt_first) begin
                        pend_bits |= bit_of(r.signo);
                        classic_word[CI_AW'(r.signo - 7'd1)] = r.info;
                    end else if (ring_step(rt_tail) == rt_head) begin
                        o.status = ST_NOBUF;
                    end else begin
                        rt_ring[QIDX_W'(rt_tail)] = {r.signo, r.info};
                        rt_tail = ring_step(rt_tail);
                    end
                    recheck = 1'b1;
                end
            end
            REQ_TAKE: begin
                m = r.use_alt ? r.operand : blk_mask;
                if (recheck || r.use_alt) begin
                    found = 1'b0;
                    for (i = rt_head; i != rt_tail; i = ring_step(i)) begin
                        if ((m & bit_of(ring_sig(i))) == '0) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) begin
                        o.dsig  = SIG_W'(ring_sig(i));
                        o.dinfo = rt_ring[QIDX_W'(i)][INFO_W-1:0];
                        if (i == rt_head) begin
                            rt_head = ring_step(rt_head);
                        end else begin
                            // close the gap: shift later entries down by one
                            for (j = ring_step(i); j != rt_tail; j = ring_step(j)) begin
                                rt_ring[QIDX_W'(i)] = rt_ring[QIDX_W'(j)];
                                i = j;
                            end
                            rt_tail = i;
                        end
                    end else begin
                        rdy = pend_bits & ~m;
                        for (int s = 1; s <= NUM_SIGNALS; s++) begin
                            if (rdy & bit_of(s)) begin
                                o.dsig  = SIG_W'(s);
                                o.dinfo = classic_word[CI_AW'(s - 1)];
                                pend_bits &= ~bit_of(s);
                                break;
                            end
                        end
                    end
                    if (o.dsig == 0) recheck = 1'b0;
                end
            end
            REQ_MASK: begin
                if (r.given) begin
                    case (r.how)
                        HOW_BLOCK:   blk_mask |= r.operand;
                        HOW_UNBLOCK: blk_mask &= ~r.operand;
                        HOW_SET:     blk_mask = r.operand;
                        default:     o.status = ST_INVAL;
                    endcase
                    // kill and stop are never blockable
                    blk_mask &= ~KILL_STOP_MASK;
                end
                if (o.old_mask & ~blk_mask) recheck = 1'b1;
            end
            REQ_READ: begin
                o.pset = pend_bits;
                for (i = rt_head; i != rt_tail; i = ring_step(i))
                    o.pset |= bit_of(ring_sig(i));
            end
            REQ_CLEAR: begin
                pend_bits = '0;
                rt_head   = 0;
                rt_tail   = 0;
            end
            default: o.status = ST_INVAL;
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic send_req(input sig_req_t r);
        while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.req_type        <= r.req_type;
        req_if.signal_number   <= r.signo;
        req_if.handler_ignored <= r.ignored;
        req_if.info_word       <= r.info;
        req_if.mask_how        <= r.how;
        req_if.mask_operand    <= r.operand;
        req_if.use_alt_mask    <= r.use_alt;
        req_if.mask_given      <= r.given;
        do @(posedge i_clk); while (!req_if.ready);
        // prediction happens at the accepting edge, in request order
        expected_rsps.push_back(predict_signal_state(r));
    endtask

    // Directed rows with a known answer also check the predictor itself.
    task automatic send_known(input sig_req_t r, input sig_rsp_t want);
        sig_rsp_t p;
        send_req(r);
        p = expected_rsps[$];
        if (p != want) begin
            $error("predictor row: expected status %0d sig %0d info %h old %h pset %h, %s",
                   want.status, want.dsig, want.dinfo, want.old_mask, want.pset,
                   $sformatf("actual status %0d sig %0d info %h old %h pset %h",
                             p.status, p.dsig, p.dinfo, p.old_mask, p.pset));
            err_cnt++;
        end
    endtask

    // Sender pauses until every expected response has come.
    task automatic hold_off();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        hold_off();
        repeat (200) @(posedge i_clk);  // longest take: full ring scan plus shifts
    endtask

    task automatic write_first_rt(input logic [SIG_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        rt_first = v;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic sig_req_t mk(input logic [2:0] t, input int unsigned s,
                                    input logic [INFO_W-1:0] inf,
                                    input logic [MASK_W-1:0] op);
        sig_req_t r;
        r = '{req_type: t, signo: SIG_W'(s), ignored: 1'b0, info: inf, how: HOW_BLOCK,
              operand: op, use_alt: 1'b0, given: 1'b1};
        return r;
    endfunction

    // Random request; mostly raises and takes so that the ring fills and drains.
    function automatic sig_req_t rand_req();
        sig_req_t r;
        int unsigned k;
        r.info    = $urandom();
        r.operand = rand_mask();
        r.how     = 2'($urandom_range(0, 3));
        r.use_alt = 1'($urandom_range(0, 1));
        r.given   = ($urandom_range(0, 7) != 0);
        r.ignored = ($urandom_range(0, 15) == 0);
        r.signo   = SIG_W'($urandom_range(1, NUM_SIGNALS));
        if ($urandom_range(0, 19) == 0) r.signo = SIG_W'($urandom_range(0, 127));
        k = $urandom_range(0, 99);
        if (k < 45)       r.req_type = REQ_RAISE;
        else if (k < 80)  r.req_type = REQ_TAKE;
        else if (k < 88)  r.req_type = REQ_MASK;
        else if (k < 95)  r.req_type = REQ_READ;
        else if (k < 98)  r.req_type = REQ_CLEAR;
        else              r.req_type = 3'($urandom_range(5, 7));
        // keep the mask loose enough that takes actually deliver
        if (r.req_type == REQ_MASK && r.how == HOW_BLOCK && $urandom_range(0, 1))
            r.operand &= {$urandom(), $urandom()} & {$urandom(), $urandom()};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side: random stalls, compare against oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("response transaction with nothing expected");
                    err_cnt++;
                end else begin
                    sig_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp_if.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, rsp_if.status);
                        err_cnt++;
                    end
                    if (rsp_if.delivered_signal !== e.dsig) begin
                        $error("delivered_signal: expected %0d, actual %0d",
                               e.dsig, rsp_if.delivered_signal);
                        err_cnt++;
                    end
                    if (rsp_if.delivered_info !== e.dinfo) begin
                        $error("delivered_info: expected %h, actual %h",
                               e.dinfo, rsp_if.delivered_info);
                        err_cnt++;
                    end
                    if (rsp_if.old_mask !== e.old_mask) begin
                        $error("old_mask: expected %h, actual %h", e.old_mask, rsp_if.old_mask);
                        err_cnt++;
                    end
                    if (rsp_if.pending_set !== e.pset) begin
                        $error("pending_set: expected %h, actual %h",
                               e.pset, rsp_if.pending_set);
                        err_cnt++;
                    end
                end
            end
            rsp_if.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: cycles without any transaction on any channel.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        sig_req_t   dir_rows [$];
        sig_rsp_t   dir_want [$];
        bit         dir_known [$];
        sig_req_t   r;
        sig_rsp_t   w;
        logic [SIG_W-1:0] frt_list [6];

        req_if.valid = 1'b0;
        req_if.req_type = REQ_READ;
        req_if.signal_number = '0;
        req_if.handler_ignored = 1'b0;
        req_if.info_word = '0;
        req_if.mask_how = HOW_BLOCK;
        req_if.mask_operand = '0;
        req_if.use_alt_mask = 1'b0;
        req_if.mask_given = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = FRT_RESET;
        reset_shadow();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Known answers are typed in where obvious.
        w = '{status: ST_OK, dsig: '0, dinfo: '0, old_mask: '0, pset: '0};
        dir_rows.push_back(mk(REQ_READ, 0, 0, 0));       dir_want.push_back(w); dir_known.push_back(1);
        // take without cause: nothing happens
        dir_rows.push_back(mk(REQ_TAKE, 0, 0, 0));       dir_want.push_back(w); dir_known.push_back(1);
        // signal zero is a no-op
        dir_rows.push_back(mk(REQ_RAISE, 0, 32'hFFFF_FFFF, 0)); dir_want.push_back(w); dir_known.push_back(1);
        w.status = ST_INVAL;
        // out of range signals
        dir_rows.push_back(mk(REQ_RAISE, 65, 0, 0));     dir_want.push_back(w); dir_known.push_back(1);
        dir_rows.push_back(mk(REQ_RAISE, 127, 0, 0));    dir_want.push_back(w); dir_known.push_back(1);
        // unknown request types
        dir_rows.push_back(mk(3'd5, 1, 0, 0));           dir_want.push_back(w); dir_known.push_back(1);
        dir_rows.push_back(mk(3'd7, 1, 0, 0));           dir_want.push_back(w); dir_known.push_back(1);
        // classic extremes, real-time extremes
        dir_rows.push_back(mk(REQ_RAISE, 1, 32'h0, 0));          dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_RAISE, 31, 32'hFFFF_FFFF, 0)); dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_RAISE, 32, 32'hA5A5_5A5A, 0)); dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_RAISE, 64, 32'h5A5A_A5A5, 0)); dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_RAISE, 5, 32'h1234, 0); r.ignored = 1'b1;     // ignored: dropped
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_READ, 0, 0, 0));               dir_known.push_back(0); dir_want.push_back(w);
        // block everything, including kill and stop (cleared by the block)
        dir_rows.push_back(mk(REQ_MASK, 0, 0, ~'0));             dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_TAKE, 0, 0, 0));               dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_MASK, 0, 0, ~'0); r.how = HOW_BAD_MODE;       // invalid mode
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_MASK, 0, 0, 0); r.given = 1'b0;               // report only
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_TAKE, 0, 0, 0); r.use_alt = 1'b1;             // alternate mask
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_MASK, 0, 0, 64'h0000_FFFF_0000_FFFF); r.how = HOW_UNBLOCK;
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_TAKE, 0, 0, 0));               dir_known.push_back(0); dir_want.push_back(w);
        r = mk(REQ_MASK, 0, 0, 0); r.how = HOW_SET;
        dir_rows.push_back(r); dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_TAKE, 0, 0, 0));               dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_CLEAR, 0, 0, 0));              dir_known.push_back(0); dir_want.push_back(w);
        dir_rows.push_back(mk(REQ_READ, 0, 0, 0));               dir_known.push_back(0); dir_want.push_back(w);

        foreach (dir_rows[k]) begin
            if (dir_known[k]) send_known(dir_rows[k], dir_want[k]);
            else              send_req(dir_rows[k]);
        end

        // Fill the ring until it reports no buffer space, then take from the middle.
        for (int k = 0; k < QUEUE_DEPTH + 1; k++)
            send_req(mk(REQ_RAISE, 33 + ($urandom_range(0, 31)), $urandom(), 0));
        r = mk(REQ_TAKE, 0, 0, 0); r.use_alt = 1'b1;
        r.operand = ~'0 ^ bit_of(40) ^ bit_of(50);
        send_req(r);
        send_req(mk(REQ_READ, 0, 0, 0));
        drain();

        // Random phases over several settings of the real-time boundary.
        frt_list = '{7'd2, 7'd64, 7'd32, 7'd17, 7'd127, 7'd48};
        foreach (frt_list[p]) begin
            write_first_rt(frt_list[p]);
            no_stall = (p == 2);
            for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
                send_req(rand_req());
                // hold off once per phase, at item 100, until the block is empty
                if (k == 100) hold_off();
            end
            no_stall = 1'b0;
            drain();
        end

        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
